@@ sv/bmg_pkg.sv @@
// bmg_pkg: shared constants, register indexes and cell data types of the
// Box-Muller Gaussian sample block. No dependencies.
package bmg_pkg;

  // default width of the uniform words that are used
  localparam int unsigned UNIFORM_BITS = 32;

  // chain lengths
  localparam int unsigned LOG_FRAC     = 30;
  localparam int unsigned SQRT_CELLS   = 31;
  localparam int unsigned HORNER_CELLS = 6;
  localparam int unsigned HORNER_LAT   = 3;
  localparam int unsigned EXP_W        = 6;

  // fixed-point constants
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [26:0] LN2_Q27    = 27'd93032640;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_OFFSET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STD_SCALE   = 8'd1;
  localparam logic [30:0] STD_SCALE_RESET = 31'd65536;

  // Horner divisors per cell; zero means the sine series skips that cell
  localparam int unsigned COS_DIV [HORNER_CELLS] = '{132, 90, 56, 30, 12, 2};
  localparam int unsigned SIN_DIV [HORNER_CELLS] = '{0, 110, 72, 42, 20, 6};

  // log2 squaring cell data
  typedef struct packed {
    logic [30:0]          y;
    logic [LOG_FRAC-1:0]  f;
    logic [EXP_W-1:0]     e;
  } log_t;

  // square root digit cell data
  typedef struct packed {
    logic [61:0] n;
    logic [32:0] r;
    logic [30:0] q;
  } sqrt_t;

  // trig side data handed along the Horner cells
  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic        use_sin;
    logic        neg;
  } trig_t;

endpackage

@@ sv/bmg_if.sv @@
// bmg_if: valid/ready channel interfaces of the Gaussian sample block
// (input uniforms, output sample, configuration writes). Uses bmg_pkg.

interface bmg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] uniform_radius;
  logic [31:0] uniform_angle;
  modport source (output valid, uniform_radius, uniform_angle, input ready);
  modport sink   (input valid, uniform_radius, uniform_angle, output ready);
endinterface

interface bmg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] gaussian_sample;
  logic        saturated;
  modport source (output valid, gaussian_sample, saturated, input ready);
  modport sink   (input valid, gaussian_sample, saturated, output ready);
endinterface

interface bmg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bmg_pkg::CFG_IDX_W-1:0]   index;
  logic [31:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/bmg_log_cell.sv @@
// bmg_log_cell: one squaring step of the log2 mantissa, yields one
// fraction bit per cell. Uses bmg_pkg::log_t.
module bmg_log_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  bmg_pkg::log_t   data_i,
  output bmg_pkg::log_t   data_o
);

  logic [61:0]   sq;
  logic [31:0]   ys;
  bmg_pkg::log_t data_d, data_q;

  // square the mantissa, renormalize when it reaches two
  always_comb begin
    sq     = 62'(data_i.y) * 62'(data_i.y);
    ys     = sq[61:30];
    data_d = data_i;
    if (ys[31]) begin
      data_d.y      = ys[31:1];
      data_d.f[BIT] = 1'b1;
    end else begin
      data_d.y = ys[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

@@ sv/bmg_sqrt_cell.sv @@
// bmg_sqrt_cell: one digit of the restoring integer square root, two
// radicand bits per cell. Uses bmg_pkg::sqrt_t.
module bmg_sqrt_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  bmg_pkg::sqrt_t  data_i,
  output bmg_pkg::sqrt_t  data_o
);

  logic [34:0]    rr;
  logic [34:0]    trial;
  bmg_pkg::sqrt_t data_d, data_q;

  // bring down two bits, try to subtract 4q+1
  always_comb begin
    rr       = {data_i.r, data_i.n[61:60]};
    trial    = 35'({data_i.q, 2'b01});
    data_d   = data_i;
    data_d.n = {data_i.n[59:0], 2'b00};
    if (rr >= trial) begin
      data_d.r = 33'(rr - trial);
      data_d.q = {data_i.q[29:0], 1'b1};
    end else begin
      data_d.r = rr[32:0];
      data_d.q = {data_i.q[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

@@ sv/bmg_horner_cell.sv @@
// bmg_horner_cell: one Horner step h = 1 - (x^2 h)/d of the cos or sin
// series, three stages. Uses bmg_pkg::trig_t and ONE_Q30.
module bmg_horner_cell #(
  parameter int unsigned DIV_COS = 2,
  parameter int unsigned DIV_SIN = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  bmg_pkg::trig_t  trig_i,
  input  logic [30:0]     h_i,
  output bmg_pkg::trig_t  trig_o,
  output logic [30:0]     h_o
);

  localparam int unsigned DS       = (DIV_SIN == 0) ? 1 : DIV_SIN;
  localparam bit          SIN_PASS = (DIV_SIN == 0);
  localparam logic [32:0] RC       = 33'(64'h1_0000_0000 / DIV_COS);
  localparam logic [32:0] RS       = 33'(64'h1_0000_0000 / DS);
  localparam logic [7:0]  DC8      = 8'(DIV_COS);
  localparam logic [7:0]  DS8      = 8'(DS);

  bmg_pkg::trig_t trig1_q, trig2_q, trig3_q;
  logic [30:0]    h1_q, h2_q, h3_q, h_d;
  logic [29:0]    p1_q, p2_q, q0_q, q;
  logic [60:0]    prod1;
  logic [62:0]    prod2;
  logic [32:0]    recip;
  logic [7:0]     div;
  logic [37:0]    qd, rem;

  // stage 1: x^2 * h
  assign prod1 = 61'(trig_i.x2) * 61'(h_i);
  // stage 2: reciprocal estimate of the quotient
  assign recip = trig1_q.use_sin ? RS : RC;
  assign prod2 = 63'(p1_q) * 63'(recip);
  // stage 3: correct the estimate by at most one
  always_comb begin
    div = trig2_q.use_sin ? DS8 : DC8;
    qd  = 38'(q0_q) * 38'(div);
    rem = 38'(p2_q) - qd;
    q   = q0_q + 30'(rem >= 38'(div));
    h_d = bmg_pkg::ONE_Q30 - 31'(q);
    if (SIN_PASS && trig2_q.use_sin) begin
      h_d = h2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig1_q <= trig_i;
      h1_q    <= h_i;
      p1_q    <= prod1[59:30];
      trig2_q <= trig1_q;
      h2_q    <= h1_q;
      p2_q    <= p1_q;
      q0_q    <= prod2[61:32];
      trig3_q <= trig2_q;
      h3_q    <= h_d;
    end
  end

  assign trig_o = trig3_q;
  assign h_o    = h3_q;

endmodule

@@ sv/box_muller_gaussian_sample.sv @@
// box_muller_gaussian_sample: top level, Box-Muller cosine branch with
// sigma scale, mu offset and saturation. Uses bmg_pkg, bmg_if and cells.
//
//  channel  | dir | payload                              | handshake
//  ---------+-----+--------------------------------------+------------
//  cfg_i    | in  | index, data                          | valid/ready
//  in_i     | in  | uniform_radius, uniform_angle        | valid/ready
//  out_o    | out | gaussian_sample, saturated           | valid/ready
//
// One request per clock while in_i.ready is high. The longest path to
// out_o runs through the 30 log2 squaring cells and 31 square root cells.
// Reset clears the pipeline valids and loads mu = 0, sigma = 1.0.
// A stalled result sits in the output register; one more is held in a
// skid register, and only then does in_i.ready drop and the chain hold.
// cfg_i.ready is always high.
module box_muller_gaussian_sample #(
  parameter int unsigned UNIFORM_BITS = bmg_pkg::UNIFORM_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmg_cfg_if.sink     cfg_i,
  bmg_in_if.sink      in_i,
  bmg_out_if.source   out_o
);

  localparam int unsigned MW       = UNIFORM_BITS + 1;
  localparam int unsigned LOG_N    = bmg_pkg::LOG_FRAC;
  localparam int unsigned SQ_N     = bmg_pkg::SQRT_CELLS;
  localparam int unsigned HN       = bmg_pkg::HORNER_CELLS;
  localparam int unsigned SQRT_END = 3 + LOG_N + 3 + SQ_N;
  localparam int unsigned TRIG_END = 4 + bmg_pkg::HORNER_LAT * HN + 1;
  localparam int unsigned DLY      = SQRT_END - TRIG_END;
  localparam int unsigned LAT      = SQRT_END + 3;
  localparam logic signed [36:0] SUM_MAX = 37'sd2147483647;
  localparam logic signed [36:0] SUM_MIN = -37'sd2147483648;

  // configuration registers
  logic [31:0] mean_q;
  logic [30:0] std_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      std_q  <= bmg_pkg::STD_SCALE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bmg_pkg::REG_MEAN_OFFSET: mean_q <= cfg_i.data;
        bmg_pkg::REG_STD_SCALE:   std_q  <= cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  // chain enable and valid shift line
  logic           pipe_en;
  logic [LAT-1:0] vld_q;
  logic           skid_vld_q, out_vld_q;

  assign pipe_en    = !skid_vld_q;
  assign in_i.ready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // stage 1: radius word plus one, phase word
  logic [MW-1:0] m1_q, m2_q;
  logic [31:0]   p1_q;
  // stage 2: leading one and angle fold
  logic [bmg_pkg::EXP_W-1:0] e_d, e2_q;
  logic [29:0]   a_d, a2_q;
  logic          sin2_q, neg2_q;
  // stage 3: normalized mantissa and angle in radians
  logic [MW+29:0] yw;
  bmg_pkg::log_t  log3_q;
  logic [61:0]    xprod;
  logic [29:0]    x3_q;
  logic           sin3_q, neg3_q;
  // stage 4: x squared
  logic [59:0]    x2prod;
  bmg_pkg::trig_t trig4_q;

  always_comb begin
    e_d = '0;
    for (int i = 0; i < MW; i++) begin
      if (m1_q[i]) begin
        e_d = bmg_pkg::EXP_W'(i);
      end
    end
    a_d = p1_q[29] ? 30'(31'h4000_0000 - {1'b0, p1_q[29:0]}) : p1_q[29:0];
    yw     = ((MW + 30)'(m2_q) << 30) >> e2_q;
    xprod  = 62'(a2_q) * 62'(bmg_pkg::TWO_PI_Q29);
    x2prod = 60'(x3_q) * 60'(x3_q);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m1_q <= MW'(in_i.uniform_radius[UNIFORM_BITS-1:0]) + MW'(1);
      p1_q <= 32'(in_i.uniform_angle[UNIFORM_BITS-1:0]) << (32 - UNIFORM_BITS);
      m2_q <= m1_q;
      e2_q <= e_d;
      a2_q <= a_d;
      sin2_q <= p1_q[30] ^ p1_q[29];
      neg2_q <= p1_q[31] ^ p1_q[30];
      log3_q.y <= yw[30:0];
      log3_q.f <= '0;
      log3_q.e <= e2_q;
      x3_q   <= xprod[60:31];
      sin3_q <= sin2_q;
      neg3_q <= neg2_q;
      trig4_q.x       <= x3_q;
      trig4_q.x2      <= x2prod[59:30];
      trig4_q.use_sin <= sin3_q;
      trig4_q.neg     <= neg3_q;
    end
  end

  // log2 squaring cells
  bmg_pkg::log_t log_c [LOG_N+1];
  assign log_c[0] = log3_q;

  for (genvar i = 0; i < LOG_N; i++) begin : g_log
    bmg_log_cell #(.BIT(LOG_N - 1 - i)) u_cell (
      .clk_i  (clk_i),
      .en_i   (pipe_en),
      .data_i (log_c[i]),
      .data_o (log_c[i+1])
    );
  end

  // t = -log2(u1), then v = -2 ln u1 over two partial products
  logic [35:0] t_d, t_q, v_q;
  logic [44:0] pph_q, ppl_q;
  logic [62:0] vsum;

  assign t_d  = ({30'd0, bmg_pkg::EXP_W'(UNIFORM_BITS) - log_c[LOG_N].e} << 30)
              - {6'd0, log_c[LOG_N].f};
  assign vsum = {pph_q, 18'd0} + 63'(ppl_q);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      t_q   <= t_d;
      pph_q <= 45'(t_q[35:18]) * 45'(bmg_pkg::LN2_Q27);
      ppl_q <= 45'(t_q[17:0]) * 45'(bmg_pkg::LN2_Q27);
      v_q   <= vsum[61:26];
    end
  end

  // square root cells
  bmg_pkg::sqrt_t sq_c [SQ_N+1];
  assign sq_c[0] = '{n: {v_q, 26'd0}, r: '0, q: '0};

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    bmg_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (pipe_en),
      .data_i (sq_c[i]),
      .data_o (sq_c[i+1])
    );
  end

  // Horner cells for cos or sin
  bmg_pkg::trig_t tr_c [HN+1];
  logic [30:0]    h_c  [HN+1];
  assign tr_c[0] = trig4_q;
  assign h_c[0]  = bmg_pkg::ONE_Q30;

  for (genvar i = 0; i < HN; i++) begin : g_horner
    bmg_horner_cell #(
      .DIV_COS (bmg_pkg::COS_DIV[i]),
      .DIV_SIN (bmg_pkg::SIN_DIV[i])
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (pipe_en),
      .trig_i (tr_c[i]),
      .h_i    (h_c[i]),
      .trig_o (tr_c[i+1]),
      .h_o    (h_c[i+1])
    );
  end

  // sine takes one more x factor; then delay to meet the root
  logic [60:0] sprod;
  logic [31:0] c_d, c_q;
  logic [31:0] c_dly_q [DLY];

  assign sprod = 61'(tr_c[HN].x) * 61'(h_c[HN]);
  assign c_d   = {tr_c[HN].neg, tr_c[HN].use_sin ? sprod[60:30] : h_c[HN]};

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      c_q <= c_d;
      c_dly_q[0] <= c_q;
      for (int i = 1; i < DLY; i++) begin
        c_dly_q[i] <= c_dly_q[i-1];
      end
    end
  end

  // product, scale with rounding, sign, offset and clip
  logic [61:0] zprod;
  logic [62:0] mprod;
  logic [30:0] zm_q;
  logic [34:0] mag_q;
  logic        neg68_q, neg69_q;
  logic signed [35:0] smag;
  logic signed [36:0] sum;
  logic [31:0] samp_d, samp_q;
  logic        sat_d, sat_q;

  always_comb begin
    zprod = 62'(sq_c[SQ_N].q) * 62'(c_dly_q[DLY-1][30:0]);
    mprod = 63'(zm_q) * 63'(std_q) + 63'(64'h800_0000);
    smag  = neg69_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    sum   = 37'(smag) + 37'($signed(mean_q));
    samp_d = sum[31:0];
    sat_d  = 1'b0;
    if (sum > SUM_MAX) begin
      samp_d = 32'h7fff_ffff;
      sat_d  = 1'b1;
    end else if (sum < SUM_MIN) begin
      samp_d = 32'h8000_0000;
      sat_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      zm_q    <= zprod[60:30];
      neg68_q <= c_dly_q[DLY-1][31];
      mag_q   <= mprod[62:28];
      neg69_q <= neg68_q;
      samp_q  <= samp_d;
      sat_q   <= sat_d;
    end
  end

  // output register with one skid entry
  logic        incoming, out_fire;
  logic [32:0] out_data_q, skid_data_q;

  assign incoming = pipe_en && vld_q[LAT-1];
  assign out_fire = out_vld_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) begin
        skid_vld_q <= 1'b0;
      end
    end else if (incoming) begin
      if (out_vld_q && !out_fire) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_data_q <= skid_data_q;
      end
    end else if (incoming) begin
      if (out_vld_q && !out_fire) begin
        skid_data_q <= {sat_q, samp_q};
      end else begin
        out_data_q <= {sat_q, samp_q};
      end
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.gaussian_sample = out_data_q[31:0];
  assign out_o.saturated       = out_data_q[32];

endmodule

@@ sv/bmg_checker.sv @@
// bmg_checker: port-level checks of the Gaussian sample block, bound to
// the top level. Depends on box_muller_gaussian_sample ports only.
module bmg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] sample_i,
  input logic        sat_i,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i
);

  // a clipped sample sits on a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sat_i |-> sample_i == 32'h7fff_ffff || sample_i == 32'h8000_0000)
    else $error("saturated sample not at a limit");

  // input only backs off after a stalled result and while one is shown
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && $past(out_valid_i && !out_ready_i))
    else $error("input ready low without output stall");

  // configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write refused");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sample_i) && $stable(sat_i))
    else $error("stalled result changed");

endmodule

bind box_muller_gaussian_sample bmg_checker u_bmg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .sample_i    (out_o.gaussian_sample),
  .sat_i       (out_o.saturated),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);
